FILE: rtl/aabb_frustum_cull_defines.svh
// Assertion macros for the box culling block.
// Included by the top level; needs clk and rst_n in the including scope.
`ifndef AABB_FRUSTUM_CULL_DEFINES_SVH
`define AABB_FRUSTUM_CULL_DEFINES_SVH

`ifndef ASSERT_OFF

// Implication checked on every rising edge outside reset.
`define AFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define AFC_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define AFC_ASSERT(label, prop, msg)
`define AFC_ASSERT_NEVER(label, cond, msg)

`endif

`endif

FILE: rtl/afc_pkg.sv
// Shared types and constants for the box culling block.
// No dependencies; used by every module of the block.
`default_nettype none

package afc_pkg;

    // Plane count and field widths.
    localparam int NUM_PLANES = 6;
    localparam int COORD_W    = 16;
    localparam int HALF_W     = 15;
    localparam int CORNER_W   = COORD_W + 1;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = COEF_W + CORNER_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int D_SHIFT    = 14;
    localparam int CFG_W      = 4 * COEF_W;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLANE_RIGHT  = 3'd0,
        REG_PLANE_LEFT   = 3'd1,
        REG_PLANE_BOTTOM = 3'd2,
        REG_PLANE_TOP    = 3'd3,
        REG_PLANE_FAR    = 3'd4,
        REG_PLANE_NEAR   = 3'd5
    } cfg_idx_t;

    // One plane as packed in its register: d in the top field, a in the bottom.
    typedef struct packed {
        logic signed [COEF_W-1:0] d;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] a;
    } plane_t;

    // Low and high corner coordinates of a box.
    typedef struct packed {
        logic signed [CORNER_W-1:0] lo_x;
        logic signed [CORNER_W-1:0] hi_x;
        logic signed [CORNER_W-1:0] lo_y;
        logic signed [CORNER_W-1:0] hi_y;
        logic signed [CORNER_W-1:0] lo_z;
        logic signed [CORNER_W-1:0] hi_z;
    } box_t;

endpackage

`default_nettype wire

FILE: rtl/aabb_frustum_cull.sv
// Top level of the box culling block: input stage, plane tests, result stage.
// Depends on afc_pkg, afc_plane_regs, afc_plane_eval and the defines header.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  input    | in_valid / in_ready    | center_x/y/z, half_x/y/z
//  result   | out_valid / out_ready  | visible
//  config   | cfg_we                 | cfg_index, cfg_data
//
// One item per cycle sustained while results are taken; a result passes the input
// register, the product registers and the result register before it is offered.
// Reset clears the stage valid bits and all planes to zero, so every box is
// culled until planes are written. A stalled result holds only the last stage;
// empty stages ahead of it keep taking items until the pipe is full.
`default_nettype none

`include "aabb_frustum_cull_defines.svh"

module aabb_frustum_cull (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [afc_pkg::COORD_W-1:0]   center_x,
    input  wire logic signed [afc_pkg::COORD_W-1:0]   center_y,
    input  wire logic signed [afc_pkg::COORD_W-1:0]   center_z,
    input  wire logic [afc_pkg::HALF_W-1:0]           half_x,
    input  wire logic [afc_pkg::HALF_W-1:0]           half_y,
    input  wire logic [afc_pkg::HALF_W-1:0]           half_z,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic                                      visible,
    input  wire logic                                 cfg_we,
    input  wire logic [afc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [afc_pkg::CFG_W-1:0]            cfg_data
);

    afc_pkg::plane_t [afc_pkg::NUM_PLANES-1:0] planes;
    afc_pkg::box_t                             box_reg;
    afc_pkg::box_t                             box_next;
    logic [afc_pkg::NUM_PLANES-1:0]            in_front;
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic visible_reg, visible_next;
    logic s1_ready, s2_ready, s3_ready;
    logic load1, load2, load3;

    // Plane configuration.
    afc_plane_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .planes    (planes)
    );

    // Stage readiness: a stage takes an item when empty or when it drains.
    always_comb
    begin
        s3_ready = !v3_reg || out_ready;
        s2_ready = !v2_reg || s3_ready;
        s1_ready = !v1_reg || s2_ready;
        load1    = in_valid && s1_ready;
        load2    = v1_reg && s2_ready;
        load3    = v2_reg && s3_ready;
        v1_next  = s1_ready ? in_valid : v1_reg;
        v2_next  = s2_ready ? v1_reg : v2_reg;
        v3_next  = s3_ready ? v2_reg : v3_reg;
    end

    // Box corners at full width, center minus and plus half-extent.
    always_comb
    begin
        box_next.lo_x = afc_pkg::CORNER_W'(center_x) - $signed({2'b00, half_x});
        box_next.hi_x = afc_pkg::CORNER_W'(center_x) + $signed({2'b00, half_x});
        box_next.lo_y = afc_pkg::CORNER_W'(center_y) - $signed({2'b00, half_y});
        box_next.hi_y = afc_pkg::CORNER_W'(center_y) + $signed({2'b00, half_y});
        box_next.lo_z = afc_pkg::CORNER_W'(center_z) - $signed({2'b00, half_z});
        box_next.hi_z = afc_pkg::CORNER_W'(center_z) + $signed({2'b00, half_z});
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            box_reg <= box_next;
        end
    end

    // One tester per plane, all working on the same box.
    for (genvar p = 0; p < afc_pkg::NUM_PLANES; p++)
    begin : g_plane
        afc_plane_eval u_eval (
            .clk      (clk),
            .load     (load2),
            .plane    (planes[p]),
            .box      (box_reg),
            .in_front (in_front[p])
        );
    end

    // Visible only if the box reaches the front side of every plane.
    assign visible_next = &in_front;

    // Result register.
    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            visible_reg <= visible_next;
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    assign in_ready  = s1_ready;
    assign out_valid = v3_reg;
    assign visible   = visible_reg;

    // An accepted item always lands in the input stage.
    `AFC_ASSERT(a_accept_fills, (in_valid && in_ready) |=> v1_reg, "accepted item lost")
    // An item moving forward always lands in the product stage.
    `AFC_ASSERT(a_move_fills, (v1_reg && s2_ready) |=> v2_reg, "item lost between stages")
    // Input is refused only when every stage holds an item.
    `AFC_ASSERT_NEVER(a_full_only, !in_ready && !(v1_reg && v2_reg && v3_reg),
        "input refused with a stage empty")

endmodule

`default_nettype wire

FILE: rtl/afc_plane_regs.sv
// Configuration store holding the six frustum planes.
// Depends on afc_pkg for the plane type and register indexes.
`default_nettype none

module afc_plane_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [afc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [afc_pkg::CFG_W-1:0]      cfg_data,
    output afc_pkg::plane_t [afc_pkg::NUM_PLANES-1:0] planes
);

    afc_pkg::plane_t [afc_pkg::NUM_PLANES-1:0] planes_reg;
    afc_pkg::plane_t [afc_pkg::NUM_PLANES-1:0] planes_next;

    // Decode the write; indexes past the last plane are dropped.
    always_comb
    begin
        planes_next = planes_reg;
        if (cfg_we)
        begin
            case (afc_pkg::cfg_idx_t'(cfg_index))
                afc_pkg::REG_PLANE_RIGHT:  planes_next[0] = afc_pkg::plane_t'(cfg_data);
                afc_pkg::REG_PLANE_LEFT:   planes_next[1] = afc_pkg::plane_t'(cfg_data);
                afc_pkg::REG_PLANE_BOTTOM: planes_next[2] = afc_pkg::plane_t'(cfg_data);
                afc_pkg::REG_PLANE_TOP:    planes_next[3] = afc_pkg::plane_t'(cfg_data);
                afc_pkg::REG_PLANE_FAR:    planes_next[4] = afc_pkg::plane_t'(cfg_data);
                afc_pkg::REG_PLANE_NEAR:   planes_next[5] = afc_pkg::plane_t'(cfg_data);
                default:                   planes_next = planes_reg;
            endcase
        end
    end

    // Plane registers; all planes clear to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            planes_reg <= '0;
        end
        else
        begin
            planes_reg <= planes_next;
        end
    end

    assign planes = planes_reg;

endmodule

`default_nettype wire

FILE: rtl/afc_plane_eval.sv
// Tests a box against one plane using its most positive corner.
// Depends on afc_pkg for the plane and box types.
`default_nettype none

module afc_plane_eval (
    input  wire logic            clk,
    input  wire logic            load,
    input  wire afc_pkg::plane_t plane,
    input  wire afc_pkg::box_t   box,
    output logic                 in_front
);

    logic signed [afc_pkg::CORNER_W-1:0] sel_x;
    logic signed [afc_pkg::CORNER_W-1:0] sel_y;
    logic signed [afc_pkg::CORNER_W-1:0] sel_z;
    logic signed [afc_pkg::PROD_W-1:0]   prod_x_reg;
    logic signed [afc_pkg::PROD_W-1:0]   prod_y_reg;
    logic signed [afc_pkg::PROD_W-1:0]   prod_z_reg;
    logic signed [afc_pkg::PROD_W-1:0]   prod_x_next;
    logic signed [afc_pkg::PROD_W-1:0]   prod_y_next;
    logic signed [afc_pkg::PROD_W-1:0]   prod_z_next;
    logic signed [afc_pkg::SUM_W-1:0]    d_scaled;
    logic signed [afc_pkg::SUM_W-1:0]    sum;

    // The corner that maximizes the plane value takes the high side where the
    // normal component is non-negative and the low side where it is negative.
    always_comb
    begin
        sel_x = plane.a[afc_pkg::COEF_W-1] ? box.lo_x : box.hi_x;
        sel_y = plane.b[afc_pkg::COEF_W-1] ? box.lo_y : box.hi_y;
        sel_z = plane.c[afc_pkg::COEF_W-1] ? box.lo_z : box.hi_z;
        prod_x_next = afc_pkg::PROD_W'(plane.a) * afc_pkg::PROD_W'(sel_x);
        prod_y_next = afc_pkg::PROD_W'(plane.b) * afc_pkg::PROD_W'(sel_y);
        prod_z_next = afc_pkg::PROD_W'(plane.c) * afc_pkg::PROD_W'(sel_z);
    end

    // Product registers, one per axis.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            prod_z_reg <= prod_z_next;
        end
    end

    // Sum with d brought to the product scale; strictly positive means in front.
    always_comb
    begin
        d_scaled = afc_pkg::SUM_W'(plane.d) <<< afc_pkg::D_SHIFT;
        sum      = afc_pkg::SUM_W'(prod_x_reg) + afc_pkg::SUM_W'(prod_y_reg)
                 + afc_pkg::SUM_W'(prod_z_reg) + d_scaled;
        in_front = !sum[afc_pkg::SUM_W-1] && (sum != '0);
    end

endmodule

`default_nettype wire
